// ===== src/rhh_pkg.sv =====
package rhh_pkg;

  localparam int HASH_W = 63;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int TAG_W  = 64;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 11;

  // A slot entry is packed as {value, key, tag}; a zero tag marks an empty slot.
  localparam int ENT_W  = TAG_W + KEY_W + VAL_W;

  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_TABLE_SIZE = 1'd0,
    REG_FILL_LIMIT = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    STOP_EMPTY,
    STOP_RICH,
    STOP_EXHAUST
  } stop_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_HOME_W,
    ST_P_RD,
    ST_P_CHK,
    ST_P_DIST,
    ST_ACT,
    ST_S_RD,
    ST_S_CHK,
    ST_M_RD,
    ST_M_WR,
    ST_PUT,
    ST_D_RD,
    ST_D_CHK,
    ST_D_HOME,
    ST_D_END,
    ST_DONE
  } state_e;

endpackage

// ===== src/rhh_ram.sv =====
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/rhh_mod_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle, busy while it runs.
module rhh_mod_unit #(
  parameter int SW = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rhh_pkg::HASH_W-1:0] dividend_i,
  input  logic [SW-1:0]             divisor_i,
  output logic                      busy_o,
  output logic [SW-1:0]             rem_o
);
  import rhh_pkg::*;

  localparam int CW = $clog2(HASH_W + 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [HASH_W-1:0] num_q, num_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [SW-1:0]     div_q, div_d;
  logic [SW:0]       trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, num_q[HASH_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(HASH_W);
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[HASH_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = SW'(trial - {1'b0, div_q});
      end else begin
        rem_d = SW'(trial);
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/robin_hood_hash_table.sv =====
// Operation steps: accept the beat, find the home slot with the remainder unit, probe slots
// (finding the home of each one that holds another key), decide, scan and move slots for an
// insert, check slots for a remove (finding the home of each occupied one), write the slot
// and present the result; clear writes every slot. Throughput: one operation at a time.
// Reset: asynchronous, active low; a clearing pass over every slot
// follows reset, during which no beat is accepted.
module robin_hood_hash_table #(
  parameter int SLOT_CAPACITY = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [rhh_pkg::CFG_W-1:0]     cfg_data_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: key_hash(63), item_key(64), item_value(64), default_value(64), pad.
  input  logic [rhh_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: op(2).
  input  logic [1:0]                    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: found(1), read_value(64), status(2), count_now(11), pad.
  output logic [rhh_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import rhh_pkg::*;

  localparam int IW = $clog2(SLOT_CAPACITY);
  localparam int SW = $clog2(SLOT_CAPACITY + 1);

  state_e state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0] table_size_q, fill_limit_q;
  logic [SW-1:0]    eff_size;

  always_comb begin
    if (table_size_q < CFG_W'(2)) begin
      eff_size = SW'(2);
    end else if (32'(table_size_q) > SLOT_CAPACITY) begin
      eff_size = SW'(SLOT_CAPACITY);
    end else begin
      eff_size = SW'(table_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= CFG_W'(1021);
      fill_limit_q <= CFG_W'(918);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_TABLE_SIZE: table_size_q <= cfg_data_i;
        REG_FILL_LIMIT: fill_limit_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Control registers.
  logic          report_q, report_d;
  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] count_q, count_d;

  // Operation registers.
  op_e              op_q, op_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] dflt_q, dflt_d;
  logic [SW-1:0]    s_q, s_d;
  logic [IW-1:0]    k_q, k_d;
  logic [IW-1:0]    e_q, e_d;
  logic [IW-1:0]    l_q, l_d;
  logic [SW-1:0]    d_q, d_d;
  logic [ENT_W-1:0] ent_q, ent_d;
  logic             hit_q, hit_d;
  stop_e            stop_q, stop_d;
  logic [VAL_W-1:0] rv_q, rv_d;
  status_e          status_q, status_d;
  logic [OUT_DATA_W-1:0] out_q, out_d;

  // Memory and remainder unit hookup.
  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic             mod_start, mod_busy;
  logic [HASH_W-1:0] mod_num;
  logic [SW-1:0]    mod_rem;

  rhh_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rhh_mod_unit #(
    .SW (SW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_num),
    .divisor_i  (s_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  // Fields of the slot just read.
  logic [TAG_W-1:0] rd_tag;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  assign rd_tag = ram_rdata[TAG_W-1:0];
  assign rd_key = ram_rdata[TAG_W+KEY_W-1:TAG_W];
  assign rd_val = ram_rdata[ENT_W-1:TAG_W+KEY_W];

  // Wrapping successor of k and e, predecessor of e, and the resident's distance from its home.
  logic [IW-1:0] k_next, e_next, e_prev, home;
  logic [SW-1:0] res_dist;
  logic          full_refuse;

  assign k_next = (SW'(k_q) + SW'(1) >= s_q) ? '0 : k_q + 1'b1;
  assign e_next = (SW'(e_q) + SW'(1) >= s_q) ? '0 : e_q + 1'b1;
  assign e_prev = (e_q == '0) ? IW'(s_q - SW'(1)) : e_q - 1'b1;
  assign home   = IW'(mod_rem);
  assign res_dist = (k_q >= home) ? SW'(k_q) - SW'(home) : s_q - SW'(home) + SW'(k_q);
  assign full_refuse = (32'(count_q) >= 32'(fill_limit_q)) || (count_q >= s_q) ||
                       (stop_q == STOP_EXHAUST);

  logic in_beat;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (k_q == IW'(SLOT_CAPACITY - 1)) begin
          state_d = report_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          state_d = (op_e'(s_axis_tuser) == OP_CLEAR) ? ST_CLEAR : ST_HOME;
        end
      end
      ST_HOME:   state_d = ST_HOME_W;
      ST_HOME_W: if (!mod_busy) state_d = ST_P_RD;
      ST_P_RD:   state_d = ST_P_CHK;
      ST_P_CHK: begin
        if (rd_tag == '0 || (rd_tag == tag_q && rd_key == key_q)) begin
          state_d = ST_ACT;
        end else begin
          state_d = ST_P_DIST;
        end
      end
      ST_P_DIST: begin
        if (!mod_busy) begin
          if (res_dist < d_q || d_q + SW'(1) >= s_q) begin
            state_d = ST_ACT;
          end else begin
            state_d = ST_P_RD;
          end
        end
      end
      ST_ACT: begin
        unique case (op_q)
          OP_INSERT: begin
            if (hit_q || full_refuse) begin
              state_d = ST_DONE;
            end else if (stop_q == STOP_EMPTY) begin
              state_d = ST_PUT;
            end else begin
              state_d = ST_S_RD;
            end
          end
          OP_REMOVE: state_d = hit_q ? ST_D_RD : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_S_RD: state_d = ST_S_CHK;
      ST_S_CHK: begin
        if (rd_tag == '0) begin
          state_d = ST_M_RD;
        end else if (d_q + SW'(1) >= s_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_S_RD;
        end
      end
      ST_M_RD: state_d = ST_M_WR;
      ST_M_WR: state_d = (l_q == k_q) ? ST_PUT : ST_M_RD;
      ST_PUT:  state_d = ST_DONE;
      ST_D_RD: state_d = ST_D_CHK;
      ST_D_CHK: state_d = (rd_tag == '0) ? ST_D_END : ST_D_HOME;
      ST_D_HOME: begin
        if (!mod_busy) begin
          if (home == e_q || d_q + SW'(1) >= s_q) begin
            state_d = ST_D_END;
          end else begin
            state_d = ST_D_RD;
          end
        end
      end
      ST_D_END: state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory port and remainder unit controls.
  always_comb begin
    report_d    = report_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    op_d        = op_q;
    tag_d       = tag_q;
    key_d       = key_q;
    val_d       = val_q;
    dflt_d      = dflt_q;
    s_d         = s_q;
    k_d         = k_q;
    e_d         = e_q;
    l_d         = l_q;
    d_d         = d_q;
    ent_d       = ent_q;
    hit_d       = hit_q;
    stop_d      = stop_q;
    rv_d        = rv_q;
    status_d    = status_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = k_q;
    ram_wdata   = '0;
    ram_raddr   = k_q;
    mod_start   = 1'b0;
    mod_num     = tag_q[TAG_W-1:1];

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        k_d    = k_q + 1'b1;
        if (k_q == IW'(SLOT_CAPACITY - 1)) begin
          count_d = '0;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          op_d     = op_e'(s_axis_tuser);
          tag_d    = {s_axis_tdata[HASH_W-1:0], 1'b1};
          key_d    = s_axis_tdata[HASH_W+KEY_W-1:HASH_W];
          val_d    = s_axis_tdata[HASH_W+KEY_W+VAL_W-1:HASH_W+KEY_W];
          dflt_d   = s_axis_tdata[HASH_W+KEY_W+2*VAL_W-1:HASH_W+KEY_W+VAL_W];
          s_d      = eff_size;
          k_d      = '0;
          d_d      = '0;
          hit_d    = 1'b0;
          rv_d     = '0;
          status_d = STAT_OK;
          report_d = 1'b1;
        end
      end
      ST_HOME: begin
        mod_start = 1'b1;
      end
      ST_HOME_W: begin
        k_d = home;
      end
      ST_P_RD: begin
        ram_raddr = k_q;
      end
      ST_P_CHK: begin
        ent_d = ram_rdata;
        if (rd_tag == '0) begin
          stop_d = STOP_EMPTY;
        end else if (rd_tag == tag_q && rd_key == key_q) begin
          hit_d = 1'b1;
          rv_d  = rd_val;
        end else begin
          mod_start = 1'b1;
          mod_num   = rd_tag[TAG_W-1:1];
        end
      end
      ST_P_DIST: begin
        if (!mod_busy) begin
          if (res_dist < d_q) begin
            stop_d = STOP_RICH;
          end else if (d_q + SW'(1) >= s_q) begin
            stop_d = STOP_EXHAUST;
          end else begin
            k_d = k_next;
            d_d = d_q + SW'(1);
          end
        end
      end
      ST_ACT: begin
        unique case (op_q)
          OP_LOOKUP: begin
            if (!hit_q) begin
              rv_d     = dflt_q;
              status_d = STAT_NOTFOUND;
            end
          end
          OP_INSERT: begin
            rv_d = '0;
            if (hit_q) begin
              ram_we    = 1'b1;
              ram_wdata = {val_q, key_q, tag_q};
            end else if (full_refuse) begin
              status_d = STAT_FULL;
            end else begin
              e_d = k_next;
              d_d = SW'(1);
            end
          end
          OP_REMOVE: begin
            rv_d = '0;
            if (hit_q) begin
              d_d = SW'(1);
            end else begin
              status_d = STAT_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      ST_S_RD: begin
        ram_raddr = e_q;
      end
      ST_S_CHK: begin
        if (rd_tag != '0) begin
          if (d_q + SW'(1) >= s_q) begin
            status_d = STAT_FULL;
          end else begin
            e_d = e_next;
            d_d = d_q + SW'(1);
          end
        end
      end
      ST_M_RD: begin
        ram_raddr = e_prev;
        l_d       = e_prev;
      end
      ST_M_WR: begin
        ram_we    = 1'b1;
        ram_waddr = e_q;
        ram_wdata = ram_rdata;
        e_d       = l_q;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = {val_q, key_q, tag_q};
        count_d   = count_q + SW'(1);
      end
      ST_D_RD: begin
        ram_raddr = k_next;
        e_d       = k_next;
      end
      ST_D_CHK: begin
        ent_d = ram_rdata;
        if (rd_tag != '0) begin
          mod_start = 1'b1;
          mod_num   = rd_tag[TAG_W-1:1];
        end
      end
      ST_D_HOME: begin
        if (!mod_busy && home != e_q) begin
          ram_we    = 1'b1;
          ram_wdata = ent_q;
          k_d       = e_q;
          d_d       = d_q + SW'(1);
        end
      end
      ST_D_END: begin
        ram_we = 1'b1;
        if (count_q != '0) begin
          count_d = count_q - SW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d = OUT_DATA_W'({CNT_W'(count_q), status_q, rv_q,
                               hit_q && (op_q != OP_CLEAR)});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tag_q    <= tag_d;
    key_q    <= key_d;
    val_q    <= val_d;
    dflt_q   <= dflt_d;
    s_q      <= s_d;
    e_q      <= e_d;
    l_q      <= l_d;
    d_q      <= d_d;
    ent_q    <= ent_d;
    hit_q    <= hit_d;
    stop_q   <= stop_d;
    rv_q     <= rv_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
